### hw/rtl/frirs_pkg.sv
// Shared types and constants for the frame rate index resampler.
package frirs_pkg;

    // Fixed field widths of the item and configuration interfaces.
    localparam int TFC_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_IDX_BITS  = 8;

    // Opcodes of an input beat.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_DELAY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_COUNT = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0] TARGET_DELAY_RESET = 16'd10;
    localparam logic [TFC_BITS-1:0]      TARGET_COUNT_RESET = 16'd1;

    // Result status codes.
    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_NO_FRAMES    = 2'd1,
        ERR_TABLE_FULL   = 2'd2,
        ERR_TARGETS_DONE = 2'd3
    } err_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_delay;
        logic clr_table;
        logic restart;
        logic err_set;
        err_t err_code;
        logic tgt_adv;
        logic zero_adv;
        logic time_add;
        logic rd_zero;
        logic mul_init;
        logic div_start;
        logic div_skip;
        logic init_until;
        logic init_done;
        logic skip_done;
        logic frame_adv;
        logic prod_load;
        logic until_add;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sc_zero;
        logic full;
        logic tgt_done;
        logic st_zero;
        logic tc_zero;
        logic time_ge_until;
        logic div_done;
    } dp_stat_t;

endpackage

### hw/rtl/frirs_div.sv
// Restoring divider that produces the remainder, one quotient bit per cycle.
module frirs_div #(
    parameter int NUM_BITS = 51,
    parameter int DEN_BITS = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [DEN_BITS-1:0] rem
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [NUM_BITS-1:0] shift_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS-1:0] rem_next;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        trial = {rem_reg, shift_reg[NUM_BITS-1]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = DEN_BITS'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[DEN_BITS-1:0];
        end
    end

    // Iteration control; the remainder stays below the divisor throughout.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            den_reg   <= den;
            shift_reg <= num;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[NUM_BITS-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/frirs_dp.sv
// Datapath: delay table, walk registers, multipliers and the remainder unit.
module frirs_dp #(
    parameter int MAX_SOURCE_FRAMES = 256,
    parameter int DELAY_BITS        = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [frirs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [frirs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic [DELAY_BITS-1:0]               s_delay_value,
    input  frirs_pkg::dp_cmd_t                  cmd,
    output frirs_pkg::dp_stat_t                 stat,
    output logic [frirs_pkg::OUT_IDX_BITS-1:0]  m_frame_index,
    output logic                                m_last_index,
    output logic [1:0]                          m_error_code
);
    import frirs_pkg::*;

    localparam int FRAME_BITS = (MAX_SOURCE_FRAMES > 1) ? $clog2(MAX_SOURCE_FRAMES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_SOURCE_FRAMES + 1);
    localparam int ST_BITS    = DELAY_BITS + CNT_BITS;
    localparam int TOT_BITS   = 2 * TFC_BITS;
    localparam int BIG_BITS   = ((ST_BITS > TOT_BITS) ? ST_BITS : TOT_BITS) + 1;
    localparam int ACC_BITS   = BIG_BITS + TFC_BITS + 2;
    localparam int DEN_BITS   = ST_BITS + TFC_BITS;
    localparam int PROD_BITS  = DELAY_BITS + TFC_BITS;

    // Delay table, written on loads and read through a registered port.
    logic [DELAY_BITS-1:0] table_mem [MAX_SOURCE_FRAMES];
    logic [DELAY_BITS-1:0] mem_q_reg;

    logic [CNT_BITS-1:0]      sc_reg;
    logic [ST_BITS-1:0]       st_reg;
    logic [CFG_DATA_BITS-1:0] td_reg;
    logic [TFC_BITS-1:0]      tfc_reg;
    logic [TFC_BITS-1:0]      tc_reg;
    logic [FRAME_BITS-1:0]    cf_reg;
    logic [ACC_BITS-1:0]      time_reg;
    logic [ACC_BITS-1:0]      until_reg;
    logic [ACC_BITS-1:0]      step_reg;
    logic [ACC_BITS-1:0]      num_reg;
    logic [TOT_BITS-1:0]      total_reg;
    logic [DEN_BITS-1:0]      span_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [FRAME_BITS-1:0]    res_idx_reg;
    logic                     res_last_reg;
    err_t                     res_err_reg;
    logic [OUT_IDX_BITS-1:0]  out_idx_reg;
    logic                     out_last_reg;
    err_t                     out_err_reg;

    logic [CNT_BITS-1:0]            cnt_base;
    logic [CNT_BITS-1:0]            cf_inc;
    logic [FRAME_BITS-1:0]          cf_wrap;
    logic [FRAME_BITS-1:0]          rd_addr;
    logic [ST_BITS-1:0]             st_base;
    logic [ACC_BITS-1:0]            loop_num_next;
    logic [DEN_BITS-1:0]            loop_den;
    logic [ACC_BITS-1:0]            div_num;
    logic [DEN_BITS-1:0]            div_den;
    logic [DEN_BITS-1:0]            div_rem;
    logic                           div_done;
    logic [ACC_BITS-1:0]            step_next;
    logic                           last_next;
    logic [FRAME_BITS+OUT_IDX_BITS-1:0] idx_ext;

    // Address and count arithmetic for loads and frame stepping.
    always_comb begin
        cnt_base = cmd.clr_table ? '0 : sc_reg;
        st_base  = cmd.clr_table ? '0 : st_reg;
        cf_inc   = CNT_BITS'(cf_reg) + CNT_BITS'(1);
        cf_wrap  = (cf_inc >= sc_reg) ? '0 : cf_inc[FRAME_BITS-1:0];
        rd_addr  = cmd.rd_zero ? '0 : cf_wrap;
    end

    // Operands of the loop-count division and the pass-skip division.
    always_comb begin
        loop_num_next = ACC_BITS'({total_reg, 1'b0}) + ACC_BITS'(st_reg);
        loop_den      = DEN_BITS'({st_reg, 1'b0});
        div_num       = cmd.div_skip ? (time_reg - until_reg) : loop_num_next;
        div_den       = cmd.div_skip ? span_reg : loop_den;
        // source_total * loops, recovered from the remainder; at least one loop.
        if (num_reg < ACC_BITS'(loop_den)) begin
            step_next = ACC_BITS'(st_reg);
        end else begin
            step_next = (num_reg - ACC_BITS'(div_rem)) >> 1;
        end
        last_next = ({1'b0, tc_reg} + (TFC_BITS+1)'(1)) == {1'b0, tfc_reg};
    end

    frirs_div #(
        .NUM_BITS (ACC_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .rem     (div_rem)
    );

    // Table write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.wr_delay) begin
            table_mem[cnt_base[FRAME_BITS-1:0]] <= s_delay_value;
        end
        mem_q_reg <= table_mem[rd_addr];
    end

    // Source table bookkeeping, configuration and walk state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg    <= '0;
            st_reg    <= '0;
            td_reg    <= TARGET_DELAY_RESET;
            tfc_reg   <= TARGET_COUNT_RESET;
            tc_reg    <= '0;
            cf_reg    <= '0;
            time_reg  <= '0;
            until_reg <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == CFG_TARGET_DELAY) begin
                td_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == CFG_TARGET_COUNT) begin
                tfc_reg <= cfg_wdata;
            end
            if (cmd.wr_delay) begin
                sc_reg <= cnt_base + CNT_BITS'(1);
                st_reg <= st_base + ST_BITS'(s_delay_value);
            end
            priority if (cmd.restart || (cfg_wr_en &&
                         (cfg_index == CFG_TARGET_DELAY || cfg_index == CFG_TARGET_COUNT))) begin
                tc_reg    <= '0;
                cf_reg    <= '0;
                time_reg  <= '0;
                until_reg <= '0;
            end else begin
                if (cmd.tgt_adv) begin
                    tc_reg <= tc_reg + TFC_BITS'(1);
                end
                if (cmd.zero_adv || cmd.frame_adv) begin
                    cf_reg <= cf_wrap;
                end
                if (cmd.time_add) begin
                    time_reg <= time_reg + step_reg;
                end else if (cmd.init_done) begin
                    time_reg <= step_next;
                end
                if (cmd.init_until) begin
                    until_reg <= ACC_BITS'(mem_q_reg * tfc_reg);
                end else if (cmd.skip_done) begin
                    until_reg <= time_reg - ACC_BITS'(div_rem);
                end else if (cmd.until_add) begin
                    until_reg <= until_reg + ACC_BITS'(prod_reg);
                end
            end
        end
    end

    // Products and division operands held between steps.
    always_ff @(posedge aclk) begin
        if (cmd.mul_init) begin
            total_reg <= td_reg * tfc_reg;
            span_reg  <= st_reg * tfc_reg;
        end
        if (cmd.div_start && !cmd.div_skip) begin
            num_reg <= loop_num_next;
        end
        if (cmd.init_done) begin
            step_reg <= step_next;
        end
        if (cmd.prod_load) begin
            prod_reg <= mem_q_reg * tfc_reg;
        end
    end

    // Pending result and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.err_set) begin
            res_idx_reg  <= '0;
            res_last_reg <= 1'b0;
            res_err_reg  <= cmd.err_code;
        end else if (cmd.tgt_adv) begin
            res_idx_reg  <= cf_reg;
            res_last_reg <= last_next;
            res_err_reg  <= ERR_OK;
        end
        if (cmd.out_load) begin
            out_idx_reg  <= idx_ext[OUT_IDX_BITS-1:0];
            out_last_reg <= res_last_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    assign idx_ext = {{OUT_IDX_BITS{1'b0}}, res_idx_reg};

    // Status toward the controller.
    always_comb begin
        stat.sc_zero       = (sc_reg == '0);
        stat.full          = (sc_reg >= CNT_BITS'(MAX_SOURCE_FRAMES));
        stat.tgt_done      = (tc_reg >= tfc_reg);
        stat.st_zero       = (st_reg == '0);
        stat.tc_zero       = (tc_reg == '0);
        stat.time_ge_until = (time_reg >= until_reg);
        stat.div_done      = div_done;
    end

    assign m_frame_index = out_idx_reg;
    assign m_last_index  = out_last_reg;
    assign m_error_code  = out_err_reg;

endmodule

### hw/rtl/frirs_ctrl.sv
// Controller state machine that sequences loads, requests and the frame walk.
module frirs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_opcode,
    input  logic                s_start_table,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  frirs_pkg::dp_stat_t stat,
    output frirs_pkg::dp_cmd_t  cmd
);
    import frirs_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_EMIT      = 10'b00_0000_0010,
        ST_INIT_MUL  = 10'b00_0000_0100,
        ST_INIT_DIV  = 10'b00_0000_1000,
        ST_INIT_WAIT = 10'b00_0001_0000,
        ST_WALK_CHK  = 10'b00_0010_0000,
        ST_WALK_DIV  = 10'b00_0100_0000,
        ST_WALK_CMP  = 10'b00_1000_0000,
        ST_WALK_RD   = 10'b01_0000_0000,
        ST_WALK_ADD  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;

    // Next state and datapath commands.
    always_comb begin
        cmd          = '0;
        cmd.err_code = ERR_OK;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_LOAD) begin
                        cmd.restart   = 1'b1;
                        cmd.clr_table = s_start_table;
                        if (stat.full && !s_start_table) begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ERR_TABLE_FULL;
                            state_next   = ST_EMIT;
                        end else begin
                            cmd.wr_delay = 1'b1;
                        end
                    end else if (stat.sc_zero) begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = ERR_NO_FRAMES;
                        state_next   = ST_EMIT;
                    end else if (stat.tgt_done) begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = ERR_TARGETS_DONE;
                        state_next   = ST_EMIT;
                    end else if (stat.st_zero) begin
                        // All delays zero: the index just counts modulo the frames.
                        cmd.tgt_adv  = 1'b1;
                        cmd.zero_adv = 1'b1;
                        state_next   = ST_EMIT;
                    end else if (stat.tc_zero) begin
                        state_next = ST_INIT_MUL;
                    end else begin
                        state_next = ST_WALK_CHK;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INIT_MUL: begin
                cmd.mul_init = 1'b1;
                cmd.rd_zero  = 1'b1;
                state_next   = ST_INIT_DIV;
            end
            ST_INIT_DIV: begin
                cmd.div_start  = 1'b1;
                cmd.init_until = 1'b1;
                state_next     = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (stat.div_done) begin
                    cmd.init_done = 1'b1;
                    cmd.tgt_adv   = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_WALK_CHK: begin
                // Skip whole passes through the source in one division.
                if (stat.time_ge_until) begin
                    cmd.div_start = 1'b1;
                    cmd.div_skip  = 1'b1;
                    state_next    = ST_WALK_DIV;
                end else begin
                    state_next = ST_WALK_CMP;
                end
            end
            ST_WALK_DIV: begin
                if (stat.div_done) begin
                    cmd.skip_done = 1'b1;
                    state_next    = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP: begin
                if (stat.time_ge_until) begin
                    cmd.frame_adv = 1'b1;
                    state_next    = ST_WALK_RD;
                end else begin
                    cmd.tgt_adv  = 1'b1;
                    cmd.time_add = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_WALK_RD: begin
                cmd.prod_load = 1'b1;
                state_next    = ST_WALK_ADD;
            end
            ST_WALK_ADD: begin
                cmd.until_add = 1'b1;
                state_next    = ST_WALK_CMP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result moves out, cleared when it is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/frame_rate_index_resampler_core.sv
// Top level of the frame rate index resampler.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    opcode, delay_value, start_table
//  m_       out        m_valid / m_ready    frame_index, last_index, error_code
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// Loads that are not refused stay in the idle state; errors and all-zero-delay requests
// pass through the emit state. The first request after a restart waits on the bit-serial
// divider that forms the loop count. Later requests also wait on the divider
// when whole passes are skipped, and step source frames one at a time through
// the single table read port. One item is in work at a time; a finished beat
// waits in the output register while the next one is accepted.
// Reset is synchronous and active low and leaves the table contents unknown.
module frame_rate_index_resampler_core #(
    parameter int MAX_SOURCE_FRAMES = 256,
    parameter int DELAY_BITS        = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [frirs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [frirs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [DELAY_BITS-1:0]               s_delay_value,
    input  logic                                s_start_table,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [frirs_pkg::OUT_IDX_BITS-1:0]  m_frame_index,
    output logic                                m_last_index,
    output logic [1:0]                          m_error_code
);
    import frirs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    frirs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_opcode      (s_opcode),
        .s_start_table (s_start_table),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    frirs_dp #(
        .MAX_SOURCE_FRAMES (MAX_SOURCE_FRAMES),
        .DELAY_BITS        (DELAY_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_delay_value (s_delay_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_frame_index (m_frame_index),
        .m_last_index  (m_last_index),
        .m_error_code  (m_error_code)
    );

endmodule

### hw/rtl/frirs_checker.sv
// Port-level checker for the resampler and its bind to the top level.
module frirs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_opcode,
    input logic       s_start_table,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_index,
    input logic       m_last_index,
    input logic [1:0] m_error_code
);
    import frirs_pkg::*;

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_index) &&
        $stable(m_last_index) && $stable(m_error_code))
        else $error("result beat changed while stalled");

    // Error beats carry index zero and no last flag.
    a_err_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |-> m_frame_index == 8'd0 && !m_last_index)
        else $error("error beat with nonzero index or last flag");

    // A load that restarts the table never produces a beat right away.
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == OP_LOAD && s_start_table |=> !$rose(m_valid))
        else $error("table restart produced a result");

    // No result beat is shown in the cycle after a reset edge.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind frame_rate_index_resampler_core frirs_checker u_frirs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .s_start_table (s_start_table),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_index (m_frame_index),
    .m_last_index  (m_last_index),
    .m_error_code  (m_error_code)
);
